@@ design/phc_pkg.sv @@
`timescale 1ns / 1ps

package phc_pkg;

    // Projections, thresholds and the crossing terms all live in a saturating 64-bit domain
    localparam int PROJ_W      = 64;
    localparam int DIR_W       = 16;
    localparam int CFG_INDEX_W = 4;

    typedef logic signed [PROJ_W-1:0] proj_t;
    typedef logic signed [DIR_W-1:0]  dir_t;
    typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;

    localparam cfg_index_t CFG_DIR_X      = 4'd0;
    localparam cfg_index_t CFG_DIR_Y      = 4'd1;
    localparam cfg_index_t CFG_CLIP_LEVEL = 4'd2;
    localparam cfg_index_t CFG_KEEP_ABOVE = 4'd3;

    localparam dir_t DIR_X_RESET      = 16'sd16384;
    localparam dir_t DIR_Y_RESET      = 16'sd0;
    localparam logic KEEP_ABOVE_RESET = 1'b1;

    localparam proj_t PROJ_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam proj_t PROJ_MIN = 64'sh8000_0000_0000_0000;

    // Request to the crossing unit: offset = trunc(num * delta / den), clamped to |delta|
    typedef struct packed {
        proj_t num;
        proj_t delta;
        proj_t den;
    } div_req_t;

    function automatic proj_t sat_add(input proj_t a, input proj_t b);
        proj_t s;
        s = a + b;
        if ((a[PROJ_W-1] == b[PROJ_W-1]) && (s[PROJ_W-1] != a[PROJ_W-1]))
            sat_add = a[PROJ_W-1] ? PROJ_MIN : PROJ_MAX;
        else
            sat_add = s;
    endfunction

    function automatic proj_t sat_sub(input proj_t a, input proj_t b);
        proj_t d;
        d = a - b;
        if ((a[PROJ_W-1] != b[PROJ_W-1]) && (d[PROJ_W-1] != a[PROJ_W-1]))
            sat_sub = a[PROJ_W-1] ? PROJ_MIN : PROJ_MAX;
        else
            sat_sub = d;
    endfunction

    function automatic logic [PROJ_W-1:0] mag(input proj_t v);
        logic [PROJ_W-1:0] u;
        u = unsigned'(v);
        mag = v[PROJ_W-1] ? (~u + 64'd1) : u;
    endfunction

    function automatic logic is_in(input proj_t p, input proj_t t, input logic keep_above);
        is_in = keep_above ? (p >= t) : (p <= t);
    endfunction

endpackage

@@ design/phc_channels.sv @@
`timescale 1ns / 1ps

interface phc_vertex_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

interface phc_result_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          vertex_valid;
    logic                          polygon_end;

    modport source (output valid, output out_x, output out_y, output vertex_valid,
                    output polygon_end, input ready);
    modport sink   (input valid, input out_x, input out_y, input vertex_valid,
                    input polygon_end, output ready);
endinterface

interface phc_cfg_if #(parameter int DATA_WIDTH = 32);
    logic                                valid;
    logic                                ready;
    logic [phc_pkg::CFG_INDEX_W-1:0]     index;
    logic [DATA_WIDTH-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/polygon_half_plane_clipper_unit.sv @@
// Sequence: accept, project x then y, evaluate, then a step per edge slot and per emitted result;
//   each crossing runs the divider (multiply, check, divide if needed, finish) for x and then for y.
// Flow: one vertex at a time, accepted only while idle; crossings go through the shared multiply/divide
//   unit (one quotient bit per cycle, x and y in turn). A result waits in the output register.
// Reset: asynchronous active low; control, configuration and polygon state return to their reset values.
`timescale 1ns / 1ps

module polygon_half_plane_clipper_unit #(
    parameter int COORD_WIDTH   = 32,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    phc_cfg_if.sink     cfg,
    phc_vertex_if.sink  vertices,
    phc_result_if.source results
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = phc_pkg::PROJ_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROJ_X = 4'd1;
    localparam logic [3:0] S_PROJ_Y = 4'd2;
    localparam logic [3:0] S_EVAL   = 4'd3;
    localparam logic [3:0] S_SLOT   = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_XSTART = 4'd6;
    localparam logic [3:0] S_XWAIT  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    typedef logic signed [CW-1:0] coord_t;

    // configuration
    phc_pkg::dir_t dir_x_reg;
    phc_pkg::dir_t dir_y_reg;
    coord_t        clip_level_reg;
    logic          keep_above_reg;

    // polygon state
    coord_t         first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    phc_pkg::proj_t first_proj_reg, prev_proj_reg;
    logic           in_polygon_reg, in_polygon_next;

    // sequencer
    logic [3:0] state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic       emitted_reg, emitted_next;
    logic       coord_y_reg, coord_y_next;
    logic       ic_reg, ic_next, ip_reg, ip_next, if_reg, if_next;

    // current item
    coord_t         cur_x_reg, cur_y_reg;
    logic           last_reg;
    phc_pkg::proj_t prod_reg, cur_proj_reg;

    // pending result and output register
    coord_t res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic   res_vv_reg, res_vv_next, res_end_reg, res_end_next;
    coord_t out_x_reg, out_y_reg;
    logic   out_vv_reg, out_end_reg;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    phc_pkg::proj_t thresh;
    coord_t         mul_a;
    phc_pkg::dir_t  mul_b;
    logic signed [CW+15:0] mul_p;
    phc_pkg::proj_t mul_ext;

    logic           e2;
    coord_t         ea_x, ea_y, eb_x, eb_y, ea_c, eb_c;
    phc_pkg::proj_t ea_p, eb_p;
    phc_pkg::div_req_t div_req;
    logic           div_start;
    logic           div_done;
    phc_pkg::proj_t div_offset;
    phc_pkg::proj_t cross_full;
    coord_t         cross_val;

    logic vin_fire;
    logic cfg_fire;

    assign cfg.ready      = 1'b1;
    assign cfg_fire       = cfg.valid && cfg.ready;
    assign vertices.ready = (state_reg == S_IDLE);
    assign vin_fire       = vertices.valid && vertices.ready;

    assign results.valid        = out_valid_reg;
    assign results.out_x        = out_x_reg;
    assign results.out_y        = out_y_reg;
    assign results.vertex_valid = out_vv_reg;
    assign results.polygon_end  = out_end_reg;

    assign thresh = PW'(clip_level_reg) <<< DIR_FRAC_BITS;

    // one projection multiplier, shared by x and y
    assign mul_a   = (state_reg == S_PROJ_Y) ? cur_y_reg : cur_x_reg;
    assign mul_b   = (state_reg == S_PROJ_Y) ? dir_y_reg : dir_x_reg;
    assign mul_p   = mul_a * mul_b;
    assign mul_ext = PW'(mul_p);

    // edge end points: slots 0 and 1 walk prev->cur, slots 2 and 3 walk the closing edge cur->first
    assign e2   = slot_reg[1];
    assign ea_x = e2 ? cur_x_reg : prev_x_reg;
    assign ea_y = e2 ? cur_y_reg : prev_y_reg;
    assign eb_x = e2 ? first_x_reg : cur_x_reg;
    assign eb_y = e2 ? first_y_reg : cur_y_reg;
    assign ea_p = e2 ? cur_proj_reg : prev_proj_reg;
    assign eb_p = e2 ? first_proj_reg : cur_proj_reg;
    assign ea_c = coord_y_reg ? ea_y : ea_x;
    assign eb_c = coord_y_reg ? eb_y : eb_x;

    assign div_req.num   = phc_pkg::sat_sub(thresh, ea_p);
    assign div_req.den   = phc_pkg::sat_sub(eb_p, ea_p);
    assign div_req.delta = PW'(eb_c) - PW'(ea_c);

    assign cross_full = PW'(ea_c) + div_offset;
    assign cross_val  = cross_full[CW-1:0];

    phc_xdiv #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_xdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .req    (div_req),
        .done   (div_done),
        .offset (div_offset)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg      <= phc_pkg::DIR_X_RESET;
            dir_y_reg      <= phc_pkg::DIR_Y_RESET;
            clip_level_reg <= '0;
            keep_above_reg <= phc_pkg::KEEP_ABOVE_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                phc_pkg::CFG_DIR_X:      dir_x_reg      <= cfg.data[phc_pkg::DIR_W-1:0];
                phc_pkg::CFG_DIR_Y:      dir_y_reg      <= cfg.data[phc_pkg::DIR_W-1:0];
                phc_pkg::CFG_CLIP_LEVEL: clip_level_reg <= cfg.data[CW-1:0];
                phc_pkg::CFG_KEEP_ABOVE: keep_above_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        emitted_next    = emitted_reg;
        coord_y_next    = coord_y_reg;
        in_polygon_next = in_polygon_reg;
        ic_next         = ic_reg;
        ip_next         = ip_reg;
        if_next         = if_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_vv_next     = res_vv_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        load_out        = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (vin_fire)
                    state_next = S_PROJ_X;
            end
            S_PROJ_X:
            begin
                state_next = S_PROJ_Y;
            end
            S_PROJ_Y:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                ic_next      = phc_pkg::is_in(cur_proj_reg, thresh, keep_above_reg);
                ip_next      = phc_pkg::is_in(prev_proj_reg, thresh, keep_above_reg);
                // a fresh polygon closes onto its own first vertex
                if_next      = in_polygon_reg ?
                               phc_pkg::is_in(first_proj_reg, thresh, keep_above_reg) :
                               phc_pkg::is_in(cur_proj_reg, thresh, keep_above_reg);
                slot_next    = 2'd0;
                emitted_next = 1'b0;
                state_next   = S_SLOT;
            end
            S_SLOT:
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        if (in_polygon_reg && ip_reg)
                        begin
                            res_x_next   = prev_x_reg;
                            res_y_next   = prev_y_reg;
                            res_vv_next  = 1'b1;
                            res_end_next = 1'b0;
                            state_next   = S_EMIT;
                        end
                        else
                            slot_next = 2'd1;
                    end
                    2'd1:
                    begin
                        if (in_polygon_reg && (ip_reg != ic_reg))
                        begin
                            // final only when the closing edge adds nothing
                            res_vv_next  = 1'b1;
                            res_end_next = last_reg && !ic_reg && !if_reg;
                            coord_y_next = 1'b0;
                            state_next   = S_XSTART;
                        end
                        else
                            slot_next = 2'd2;
                    end
                    2'd2:
                    begin
                        if (last_reg && ic_reg)
                        begin
                            res_x_next   = cur_x_reg;
                            res_y_next   = cur_y_reg;
                            res_vv_next  = 1'b1;
                            res_end_next = (ic_reg == if_reg);
                            state_next   = S_EMIT;
                        end
                        else
                            slot_next = 2'd3;
                    end
                    default:
                    begin
                        if (last_reg && (ic_reg != if_reg))
                        begin
                            res_vv_next  = 1'b1;
                            res_end_next = 1'b1;
                            coord_y_next = 1'b0;
                            state_next   = S_XSTART;
                        end
                        else if (last_reg && !emitted_reg)
                        begin
                            // empty clipped polygon: end marker only
                            res_x_next   = '0;
                            res_y_next   = '0;
                            res_vv_next  = 1'b0;
                            res_end_next = 1'b1;
                            state_next   = S_EMIT;
                        end
                        else
                            state_next = S_DONE;
                    end
                endcase
            end
            S_XSTART:
            begin
                div_start  = 1'b1;
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (div_done)
                begin
                    if (!coord_y_reg)
                    begin
                        res_x_next   = cross_val;
                        coord_y_next = 1'b1;
                        state_next   = S_XSTART;
                    end
                    else
                    begin
                        res_y_next = cross_val;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    emitted_next   = 1'b1;
                    if (slot_reg == 2'd3)
                        state_next = S_DONE;
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = S_SLOT;
                    end
                end
            end
            S_DONE:
            begin
                in_polygon_next = !last_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_reg       <= 2'd0;
            emitted_reg    <= 1'b0;
            coord_y_reg    <= 1'b0;
            in_polygon_reg <= 1'b0;
            ic_reg         <= 1'b0;
            ip_reg         <= 1'b0;
            if_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            first_proj_reg <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_proj_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            emitted_reg    <= emitted_next;
            coord_y_reg    <= coord_y_next;
            in_polygon_reg <= in_polygon_next;
            ic_reg         <= ic_next;
            ip_reg         <= ip_next;
            if_reg         <= if_next;
            out_valid_reg  <= out_valid_next;
            if ((state_reg == S_EVAL) && !in_polygon_reg)
            begin
                first_x_reg    <= cur_x_reg;
                first_y_reg    <= cur_y_reg;
                first_proj_reg <= cur_proj_reg;
            end
            if (state_reg == S_DONE)
            begin
                prev_x_reg    <= cur_x_reg;
                prev_y_reg    <= cur_y_reg;
                prev_proj_reg <= cur_proj_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vin_fire)
        begin
            cur_x_reg <= vertices.vertex_x;
            cur_y_reg <= vertices.vertex_y;
            last_reg  <= vertices.last_vertex;
        end
        if (state_reg == S_PROJ_X)
            prod_reg <= mul_ext;
        if (state_reg == S_PROJ_Y)
            cur_proj_reg <= phc_pkg::sat_add(prod_reg, mul_ext);
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_vv_reg  <= res_vv_next;
        res_end_reg <= res_end_next;
        if (load_out)
        begin
            out_x_reg   <= res_x_reg;
            out_y_reg   <= res_y_reg;
            out_vv_reg  <= res_vv_reg;
            out_end_reg <= res_end_reg;
        end
    end

endmodule

@@ design/phc_xdiv.sv @@
`timescale 1ns / 1ps

module phc_xdiv #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  phc_pkg::div_req_t         req,
    output logic                      done,
    output phc_pkg::proj_t            offset
);

    localparam int CW    = COORD_WIDTH;
    localparam int PW    = phc_pkg::PROJ_W;
    localparam int ACC_W = PW + CW;
    localparam int CNT_W = $clog2(CW + 1);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_MUL  = 3'd1;
    localparam logic [2:0] D_CHK  = 3'd2;
    localparam logic [2:0] D_DIV  = 3'd3;
    localparam logic [2:0] D_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PW-1:0]    a_reg;
    logic [CW-1:0]    b_reg;
    logic [PW-1:0]    d_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [1:0]       k_reg;
    logic [PW-1:0]    rem_reg;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [CW-1:0]    delta_mag;
    logic [PW-1:0]    b_pad;
    logic [31:0]      a_part;
    logic [31:0]      b_part;
    logic [63:0]      pp;
    logic [ACC_W-1:0] pp_ext;
    logic [ACC_W-1:0] pp_sh;
    logic [PW-1:0]    hi;
    logic [PW:0]      trial;
    logic [PW:0]      dpad;
    logic             ge;
    logic [PW:0]      diff;
    logic [CW-1:0]    qc;
    logic [PW-1:0]    q_ext;

    // |delta| always fits in CW bits
    assign delta_mag = CW'(phc_pkg::mag(req.delta));

    // One 32x32 partial product per cycle: a is 64 bits, |delta| fits in two 32-bit halves
    assign b_pad  = PW'(b_reg);
    assign a_part = k_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = k_reg[0] ? b_pad[63:32] : b_pad[31:0];
    assign pp     = a_part * b_part;
    assign pp_ext = ACC_W'(pp);
    assign pp_sh  = (k_reg[1] & k_reg[0]) ? (pp_ext << 64) :
                    (k_reg[1] | k_reg[0]) ? (pp_ext << 32) : pp_ext;

    assign hi    = acc_reg[ACC_W-1:CW];
    assign trial = {rem_reg, lo_reg[CW-1]};
    assign dpad  = {1'b0, d_reg};
    assign ge    = (trial >= dpad);
    assign diff  = trial - dpad;

    assign qc     = (q_reg > b_reg) ? b_reg : q_reg;
    assign q_ext  = PW'(qc);
    assign offset = neg_reg ? signed'(-q_ext) : signed'(q_ext);
    assign done   = (state_reg == D_FIN);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = D_MUL;
            end
            D_MUL:
            begin
                if (k_reg == 2'd3)
                    state_next = D_CHK;
            end
            D_CHK:
            begin
                if ((d_reg == '0) || (hi >= d_reg))
                    state_next = D_FIN;
                else
                    state_next = D_DIV;
            end
            D_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = D_FIN;
            end
            D_FIN:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= D_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    a_reg   <= phc_pkg::mag(req.num);
                    b_reg   <= delta_mag;
                    d_reg   <= phc_pkg::mag(req.den);
                    neg_reg <= req.num[PW-1] ^ req.delta[PW-1] ^ req.den[PW-1];
                    acc_reg <= '0;
                    k_reg   <= 2'd0;
                end
            end
            D_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                k_reg   <= k_reg + 2'd1;
            end
            D_CHK:
            begin
                // Zero divisor gives zero; a high part at or above d means the quotient exceeds
                // |delta| and clamps to it
                if (d_reg == '0)
                    q_reg <= '0;
                else if (hi >= d_reg)
                    q_reg <= b_reg;
                else
                    q_reg <= '0;
                rem_reg <= hi;
                lo_reg  <= acc_reg[CW-1:0];
                cnt_reg <= CNT_W'(CW);
            end
            D_DIV:
            begin
                rem_reg <= ge ? diff[PW-1:0] : trial[PW-1:0];
                q_reg   <= {q_reg[CW-2:0], ge};
                lo_reg  <= {lo_reg[CW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ design/phc_checker.sv @@
`timescale 1ns / 1ps

module phc_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   vin_valid,
    input logic                   vin_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [COORD_WIDTH-1:0] res_x,
    input logic [COORD_WIDTH-1:0] res_y,
    input logic                   res_vertex_valid,
    input logic                   res_polygon_end
);

    // an end marker without a vertex always closes the polygon
    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_vertex_valid) |-> res_polygon_end)
        else $error("end marker without polygon_end");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_vertex_valid) |-> ((res_x == '0) && (res_y == '0)))
        else $error("end marker carries nonzero coordinates");

    // one vertex in flight: input drops ready right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (vin_valid && vin_ready) |=> !vin_ready)
        else $error("vertex accepted while previous one is in work");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_x) && $stable(res_y)))
        else $error("stalled result changed");

endmodule

bind polygon_half_plane_clipper_unit phc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_phc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .vin_valid        (vertices.valid),
    .vin_ready        (vertices.ready),
    .res_valid        (results.valid),
    .res_ready        (results.ready),
    .res_x            (results.out_x),
    .res_y            (results.out_y),
    .res_vertex_valid (results.vertex_valid),
    .res_polygon_end  (results.polygon_end)
);

@@ test/tb_polygon_half_plane_clipper_unit.sv @@
`timescale 1ns / 1ps

module tb_polygon_half_plane_clipper_unit;

    localparam int COORD_W       = 32;
    localparam int DIR_FRAC      = 14;
    localparam int ONE           = 65536;
    localparam int DIR_ONE       = 16384;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS  = 190;
    localparam int MAX_PRINTED   = 40;
    localparam int COORD_MAX     = int'(32'h7FFF_FFFF);
    localparam int COORD_MIN     = int'(32'h8000_0000);
    localparam phc_pkg::cfg_index_t CFG_SPARE = 4'd13;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   vertex_valid;
        logic   polygon_end;
    } clip_vertex_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    phc_cfg_if #(.DATA_WIDTH(32))          cfg_ch ();
    phc_vertex_if #(.COORD_WIDTH(COORD_W)) vtx_ch ();
    phc_result_if #(.COORD_WIDTH(COORD_W)) res_ch ();

    polygon_half_plane_clipper_unit #(
        .COORD_WIDTH(COORD_W),
        .DIR_FRAC_BITS(DIR_FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch.sink),
        .vertices(vtx_ch.sink),
        .results(res_ch.source)
    );

    // Clip plane as the block should currently see it
    phc_pkg::dir_t plane_dir_x      = phc_pkg::DIR_X_RESET;
    phc_pkg::dir_t plane_dir_y      = phc_pkg::DIR_Y_RESET;
    coord_t        plane_level      = '0;
    logic          plane_keep_above = phc_pkg::KEEP_ABOVE_RESET;

    // Polygon tracking
    coord_t first_x, first_y, prev_x, prev_y;
    longint first_proj, prev_proj;
    bit     open_polygon = 1'b0;

    clip_vertex_t expected_vertices[$];
    clip_vertex_t step_vertices[$];
    int           error_count = 0;
    bit           gaps_on = 1'b1;

    always #5 clk = ~clk;

    function automatic longint project_vertex(coord_t x, coord_t y);
        return longint'(x) * longint'(plane_dir_x) + longint'(y) * longint'(plane_dir_y);
    endfunction

    function automatic longint plane_threshold();
        return longint'(plane_level) * (longint'(1) << DIR_FRAC);
    endfunction

    function automatic bit kept(longint p);
        return plane_keep_above ? (p >= plane_threshold()) : (p <= plane_threshold());
    endfunction

    // trunc(num * delta / den), magnitude clamped to |delta|
    function automatic longint crossing_offset(longint num, longint delta, longint den);
        logic [127:0] quot;
        logic [63:0]  abs_num, abs_delta, abs_den;
        abs_num   = (num < 0) ? -num : num;
        abs_delta = (delta < 0) ? -delta : delta;
        abs_den   = (den < 0) ? -den : den;
        if (abs_den == 64'd0)
            return 0;
        quot = ({64'd0, abs_num} * {64'd0, abs_delta}) / {64'd0, abs_den};
        if (quot > {64'd0, abs_delta})
            quot = {64'd0, abs_delta};
        if ((num < 0) ^ (delta < 0) ^ (den < 0))
            return -longint'(quot[63:0]);
        return longint'(quot[63:0]);
    endfunction

    function automatic void emit(coord_t x, coord_t y, logic carries_vertex);
        clip_vertex_t v;
        v.x            = x;
        v.y            = y;
        v.vertex_valid = carries_vertex;
        v.polygon_end  = 1'b0;
        step_vertices.insert(step_vertices.size(), v);
    endfunction

    function automatic void clip_edge(coord_t ax, coord_t ay, longint pa,
                                      coord_t bx, coord_t by, longint pb);
        longint num, den, cx, cy;
        bit     a_in, b_in;
        a_in = kept(pa);
        b_in = kept(pb);
        if (a_in)
            emit(ax, ay, 1'b1);
        if (a_in != b_in)
        begin
            num = plane_threshold() - pa;
            den = pb - pa;
            cx  = longint'(ax) + crossing_offset(num, longint'(bx) - longint'(ax), den);
            cy  = longint'(ay) + crossing_offset(num, longint'(by) - longint'(ay), den);
            emit(cx[COORD_W-1:0], cy[COORD_W-1:0], 1'b1);
        end
    endfunction

    function automatic void predict_clip(coord_t x, coord_t y, logic last);
        longint p;
        p = project_vertex(x, y);
        step_vertices.delete();
        if (!open_polygon)
        begin
            first_x      = x;
            first_y      = y;
            first_proj   = p;
            open_polygon = 1'b1;
        end
        else
            clip_edge(prev_x, prev_y, prev_proj, x, y, p);
        prev_x    = x;
        prev_y    = y;
        prev_proj = p;
        if (last)
        begin
            // closing edge back to the first vertex
            clip_edge(x, y, p, first_x, first_y, first_proj);
            if (step_vertices.size() == 0)
                emit('0, '0, 1'b0);
            step_vertices[step_vertices.size()-1].polygon_end = 1'b1;
            open_polygon = 1'b0;
        end
        foreach (step_vertices[i])
            expected_vertices.insert(expected_vertices.size(), step_vertices[i]);
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        clip_vertex_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_vertices.size() == 0)
                report_mismatch($sformatf("unexpected transaction x=%h y=%h",
                                          res_ch.out_x, res_ch.out_y));
            else
            begin
                want = expected_vertices.pop_front();
                if (res_ch.out_x !== want.x)
                    report_mismatch($sformatf("out_x %h, want %h", res_ch.out_x, want.x));
                if (res_ch.out_y !== want.y)
                    report_mismatch($sformatf("out_y %h, want %h", res_ch.out_y, want.y));
                if (res_ch.vertex_valid !== want.vertex_valid)
                    report_mismatch($sformatf("vertex_valid %b, want %b",
                                              res_ch.vertex_valid, want.vertex_valid));
                if (res_ch.polygon_end !== want.polygon_end)
                    report_mismatch($sformatf("polygon_end %b, want %b",
                                              res_ch.polygon_end, want.polygon_end));
            end
        end
    end

    // Result side: random stall before each transaction while gaps_on is set
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    task automatic send_vertex(coord_t x, coord_t y, logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            vtx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_ch.vertex_x    <= x;
        vtx_ch.vertex_y    <= y;
        vtx_ch.last_vertex <= last;
        vtx_ch.valid       <= 1'b1;
        @(posedge clk);
        while (vtx_ch.ready !== 1'b1)
            @(posedge clk);
        predict_clip(x, y, last);
    endtask

    // Drop valid, drain every expected result, then let a pending vertex finish
    task automatic wait_idle();
        vtx_ch.valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(phc_pkg::cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            phc_pkg::CFG_DIR_X:      plane_dir_x      = value[phc_pkg::DIR_W-1:0];
            phc_pkg::CFG_DIR_Y:      plane_dir_y      = value[phc_pkg::DIR_W-1:0];
            phc_pkg::CFG_CLIP_LEVEL: plane_level      = value;
            phc_pkg::CFG_KEEP_ABOVE: plane_keep_above = value[0];
            default: ;
        endcase
    endtask

    task automatic set_plane(int dx, int dy, int level, bit keep);
        write_reg(phc_pkg::CFG_DIR_X, dx);
        write_reg(phc_pkg::CFG_DIR_Y, dy);
        write_reg(phc_pkg::CFG_CLIP_LEVEL, level);
        write_reg(phc_pkg::CFG_KEEP_ABOVE, keep);
    endtask

    function automatic int small_level();
        return int'($urandom_range(0, 4194304)) - 2097152;
    endfunction

    function automatic coord_t random_coord(bit wide);
        if (wide)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endfunction

    task automatic randomize_plane();
        int dx, dy, level;
        dx    = int'($urandom_range(0, 2 * DIR_ONE)) - DIR_ONE;
        dy    = int'($urandom_range(0, 2 * DIR_ONE)) - DIR_ONE;
        level = small_level();
        case ($urandom_range(0, 3))
            0:
            begin
                dx = (int'($urandom_range(0, 2)) - 1) * DIR_ONE;
                dy = (int'($urandom_range(0, 2)) - 1) * DIR_ONE;
            end
            1: level = int'($urandom);
            default: ;
        endcase
        set_plane(dx, dy, level, $urandom_range(0, 1));
    endtask

    task automatic test_default_plane();
        // rectangle across x = 0
        send_vertex(-2 * ONE, -1 * ONE, 1'b0);
        send_vertex( 2 * ONE, -1 * ONE, 1'b0);
        send_vertex( 2 * ONE,  1 * ONE, 1'b0);
        send_vertex(-2 * ONE,  1 * ONE, 1'b1);
        // single vertex inside, then outside
        send_vertex(ONE, ONE, 1'b1);
        send_vertex(-ONE, 0, 1'b1);
        // whole triangle outside
        send_vertex(-ONE, 0, 1'b0);
        send_vertex(-3 * ONE, 2 * ONE, 1'b0);
        send_vertex(-2 * ONE, -5 * ONE, 1'b1);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        set_plane(DIR_ONE, -DIR_ONE, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(0, 0, 1'b1);
        wait_idle();
        set_plane(-DIR_ONE, DIR_ONE, COORD_MAX, 1'b1);
        // unmapped index must leave the plane alone
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(0, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_mid_polygon();
        set_plane(DIR_ONE, 0, 3 * ONE, 1'b1);
        // first vertex sits exactly on the boundary
        send_vertex(3 * ONE, 0, 1'b0);
        send_vertex(5 * ONE, ONE, 1'b0);
        wait_idle();
        write_reg(phc_pkg::CFG_KEEP_ABOVE, 1'b0);
        write_reg(phc_pkg::CFG_CLIP_LEVEL, 4 * ONE);
        send_vertex(ONE, 2 * ONE, 1'b0);
        send_vertex(4 * ONE, -2 * ONE, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_polygons();
        int sent, corners;
        bit wide;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wait_idle();
                randomize_plane();
            end
            if ($urandom_range(0, 5) == 0)
                gaps_on = ~gaps_on;
            wide    = ($urandom_range(0, 4) == 0);
            corners = $urandom_range(1, 8);
            for (int i = 0; i < corners; i++)
            begin
                if (i > 0 && $urandom_range(0, 19) == 0)
                begin
                    wait_idle();
                    write_reg(phc_pkg::CFG_CLIP_LEVEL, small_level());
                end
                send_vertex(random_coord(wide), random_coord(wide), i == corners - 1);
            end
            sent += corners;
        end
        wait_idle();
    endtask

    initial
    begin
        vtx_ch.valid       <= 1'b0;
        vtx_ch.vertex_x    <= '0;
        vtx_ch.vertex_y    <= '0;
        vtx_ch.last_vertex <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_default_plane();
        test_register_extremes();
        test_config_mid_polygon();
        test_random_polygons();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
